// ===== rtl/utf8_to_cp437_transcoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to CP437 transcoder
// Shared concurrent-assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CP437_TRANSCODER_MACROS_SVH
`define UTF8_TO_CP437_TRANSCODER_MACROS_SVH

// same-cycle implication
`define U2C_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U2C_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c_pkg
// Types, constants and decode helpers shared by the transcoder modules.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam int CountBitsDefault  = 16;
  localparam int QueueDepthDefault = 4;
  localparam int CfgW              = 16;
  localparam logic [CfgW-1:0] MaxCharsReset = 16'd255;

  // lead byte class masks
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;
  localparam logic [7:0] LeadBits  = 8'h1F;
  localparam logic [7:0] TailBits  = 8'h3F;

  localparam logic [7:0] CharUnknown = 8'h3F;  // '?'
  localparam logic [7:0] CharNul     = 8'h00;

  // byte classes
  typedef enum logic [2:0] {
    K_NUL   = 3'd0,
    K_ASCII = 3'd1,
    K_CONT  = 3'd2,
    K_LEAD2 = 3'd3,
    K_LEAD3 = 3'd4,
    K_LEAD4 = 3'd5,
    K_BAD   = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } entry_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  // NUL flush sequencing
  typedef enum logic [2:0] {
    PH_CHAR0 = 3'b001,
    PH_CHAR1 = 3'b010,
    PH_TERM  = 3'b100
  } phase_e;

  function automatic logic is_lead2(input logic [7:0] b);
    is_lead2 = (b & Lead2Mask) == Lead2Val;
  endfunction

  function automatic logic is_lead3(input logic [7:0] b);
    is_lead3 = (b & Lead3Mask) == Lead3Val;
  endfunction

  function automatic logic is_lead4(input logic [7:0] b);
    is_lead4 = (b & Lead4Mask) == Lead4Val;
  endfunction

  // two-byte sequence to CP437; unknown code points give '?'
  function automatic logic [7:0] map_pair(input logic [7:0] lead, input logic [7:0] tail);
    logic [10:0] cp;
    cp = {lead[4:0] & LeadBits[4:0], tail[5:0] & TailBits[5:0]};
    case (cp)
      11'h0C4: map_pair = 8'h8E;
      11'h0D6: map_pair = 8'h99;
      11'h0DC: map_pair = 8'h9A;
      11'h0E4: map_pair = 8'h84;
      11'h0F6: map_pair = 8'h94;
      11'h0FC: map_pair = 8'h81;
      11'h0DF: map_pair = 8'hE1;
      11'h0E9: map_pair = 8'h82;
      11'h0E8: map_pair = 8'h8A;
      11'h0E0: map_pair = 8'h85;
      default: map_pair = CharUnknown;
    endcase
  endfunction

endpackage

// ===== rtl/u2c_front.sv =====
// ----------------------------------------------------------------------------
// u2c_front
// Accepts source bytes and tags each with its UTF-8 byte class.
// ----------------------------------------------------------------------------
module u2c_front import u2c_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output entry_t     entry_o
);

  kind_e kind;

  always_comb begin
    if (in_byte_i == CharNul) begin
      kind = K_NUL;
    end else if (!in_byte_i[7]) begin
      kind = K_ASCII;
    end else if (is_lead2(in_byte_i)) begin
      kind = K_LEAD2;
    end else if (is_lead3(in_byte_i)) begin
      kind = K_LEAD3;
    end else if (is_lead4(in_byte_i)) begin
      kind = K_LEAD4;
    end else if (!in_byte_i[6]) begin
      kind = K_CONT;
    end else begin
      kind = K_BAD;
    end
  end

  assign in_ready_o    = !full_i;
  assign push_o        = in_valid_i && !full_i;
  assign entry_o.kind  = kind;
  assign entry_o.data  = in_byte_i;

endmodule

// ===== rtl/u2c_queue.sv =====
// ----------------------------------------------------------------------------
// u2c_queue
// Small FIFO of classified beats between front and back end.
// ----------------------------------------------------------------------------
module u2c_queue import u2c_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  entry_t  entry_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_head_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= entry_i;
    end
  end

  assign head_o.valid = cnt_q != '0;
  assign head_o.entry = mem[rd_q];

endmodule

// ===== rtl/u2c_back.sv =====
// ----------------------------------------------------------------------------
// u2c_back
// Sequence decoder and output register: one result beat per cycle, none while the output is stalled.
// ----------------------------------------------------------------------------
module u2c_back import u2c_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CfgW-1:0] max_chars_i,
  input  q_head_t         head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            last_o
);

`include "utf8_to_cp437_transcoder_macros.svh"

  localparam int LimW = (COUNT_BITS > CfgW) ? COUNT_BITS : CfgW;

  logic [7:0]            lead_q, lead_d, tail0_q, tail0_d, tail1_q, tail1_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [COUNT_BITS-1:0] chars_q, chars_d;
  phase_e                phase_q, phase_d;
  logic                  out_valid_q;
  logic [7:0]            out_char_q;
  logic                  out_last_q;

  logic [LimW-1:0] max_ext, mask_ext, limit, chars_ext;
  logic            room, out_free, emit, emit_last;
  logic [7:0]      emit_char;
  logic            va, vb;
  logic [7:0]      ca, cb;
  kind_e           kind;
  logic [7:0]      data;

  // limit is the smaller of the register and the counter's all-ones value
  assign max_ext   = LimW'(max_chars_i);
  assign mask_ext  = LimW'({COUNT_BITS{1'b1}});
  assign limit     = (max_ext < mask_ext) ? max_ext : mask_ext;
  assign chars_ext = LimW'(chars_q);
  assign room      = chars_ext < limit;
  assign out_free  = !out_valid_q || out_ready_i;
  assign kind      = head_i.entry.kind;
  assign data      = head_i.entry.data;

  // chars recovered from a cut sequence, compacted so vb implies va
  always_comb begin
    va = 1'b0;
    vb = 1'b0;
    ca = tail0_q;
    cb = tail1_q;
    if (lead_q != 8'd0 && cnt_q != 2'd0) begin
      if (!tail0_q[7]) begin
        va = 1'b1;
        vb = (cnt_q == 2'd2) && !tail1_q[7];
      end else if (is_lead2(tail0_q) && cnt_q == 2'd2) begin
        va = 1'b1;
        ca = map_pair(tail0_q, tail1_q);
      end else if (cnt_q == 2'd2 && !tail1_q[7]) begin
        va = 1'b1;
        ca = tail1_q;
      end
    end
  end

  always_comb begin
    lead_d    = lead_q;
    tail0_d   = tail0_q;
    tail1_d   = tail1_q;
    cnt_d     = cnt_q;
    chars_d   = chars_q;
    phase_d   = phase_q;
    emit      = 1'b0;
    emit_char = data;
    emit_last = 1'b0;
    pop_o     = 1'b0;
    if (head_i.valid && out_free) begin
      if (kind == K_NUL) begin
        emit = 1'b1;
        case (phase_q)
          PH_CHAR0: begin
            if (va && room) begin
              emit_char = ca;
              phase_d   = PH_CHAR1;
            end else begin
              emit_last = 1'b1;
            end
          end
          PH_CHAR1: begin
            if (vb && room) begin
              emit_char = cb;
              phase_d   = PH_TERM;
            end else begin
              emit_last = 1'b1;
            end
          end
          default: emit_last = 1'b1;
        endcase
        if (emit_last) begin
          emit_char = CharNul;
          pop_o     = 1'b1;
          lead_d    = 8'd0;
          tail0_d   = 8'd0;
          tail1_d   = 8'd0;
          cnt_d     = 2'd0;
          chars_d   = '0;
          phase_d   = PH_CHAR0;
        end else begin
          chars_d = chars_q + COUNT_BITS'(1);
        end
      end else begin
        pop_o = 1'b1;
        if (lead_q != 8'd0) begin
          // pending sequence: this byte is a continuation, whatever its value
          if (is_lead2(lead_q) || (is_lead3(lead_q) && cnt_q != 2'd0) ||
              (!is_lead2(lead_q) && !is_lead3(lead_q) && cnt_q == 2'd2)) begin
            emit_char = is_lead2(lead_q) ? map_pair(lead_q, data) : CharUnknown;
            emit      = room;
            lead_d    = 8'd0;
            tail0_d   = 8'd0;
            tail1_d   = 8'd0;
            cnt_d     = 2'd0;
          end else begin
            if (cnt_q[0]) begin
              tail1_d = data;
            end else begin
              tail0_d = data;
            end
            cnt_d = cnt_q + 2'd1;
          end
        end else if (room) begin
          case (kind)
            K_ASCII: emit = 1'b1;
            K_LEAD2, K_LEAD3, K_LEAD4: begin
              lead_d = data;
              cnt_d  = 2'd0;
            end
            default: ;
          endcase
        end
        if (emit) begin
          chars_d = chars_q + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q      <= 8'd0;
      tail0_q     <= 8'd0;
      tail1_q     <= 8'd0;
      cnt_q       <= 2'd0;
      chars_q     <= '0;
      phase_q     <= PH_CHAR0;
      out_valid_q <= 1'b0;
    end else begin
      lead_q  <= lead_d;
      tail0_q <= tail0_d;
      tail1_q <= tail1_d;
      cnt_q   <= cnt_d;
      chars_q <= chars_d;
      phase_q <= phase_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

  `U2C_ASSERT_IMP(a_no_lead_no_tails, clk_i, rst_ni, lead_q == 8'd0, cnt_q == 2'd0, "tails held without a lead")
  `U2C_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3, "held count out of range")
  `U2C_ASSERT_IMP(a_flush_on_nul, clk_i, rst_ni, phase_q != PH_CHAR0, head_i.valid && kind == K_NUL, "flush without NUL at head")
  `U2C_ASSERT_NXT(a_term_clears, clk_i, rst_ni, emit && emit_last, chars_q == '0 && lead_q == 8'd0 && phase_q == PH_CHAR0, "terminator left state behind")

endmodule

// ===== rtl/utf8_to_cp437_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_cp437_transcoder
// UTF-8 byte stream to CP437 characters, one source byte per beat.
// ----------------------------------------------------------------------------
// Feed a NUL-terminated UTF-8 string one byte per input beat; the block
// returns CP437 characters one per output beat and closes every string with
// a terminator beat (char 0, last_o high). Throughput is one input beat per
// cycle for ordinary bytes while the queue has room and the output is not
// stalled: a byte is classified and queued on entry, and the decoder at the
// back end retires one queued beat per cycle, so a byte yields at most one
// character. The NUL byte is the exception: if a multi-byte sequence was cut
// short, up to two characters recovered from the held bytes go out before
// the terminator, so a NUL holds the decoder while they go out, the queue
// absorbing the input meanwhile. An input byte passes through the queue and
// the output register before its character appears. max_chars (written
// through the config channel, reset 255) caps characters per string; once
// reached the rest of the string is swallowed up to its terminator. Write it only while no string is in flight.
// ----------------------------------------------------------------------------
module utf8_to_cp437_transcoder import u2c_pkg::*; #(
  parameter int COUNT_BITS  = CountBitsDefault,  // per-string char counter width
  parameter int QUEUE_DEPTH = QueueDepthDefault  // front-to-back decoupling queue
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // source bytes
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  // CP437 result beats
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            last_o,
  // max_chars write channel
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CfgW-1:0] max_chars_i
);

  logic [CfgW-1:0] max_chars_q;
  logic            q_full, q_push, q_pop;
  entry_t          q_entry;
  q_head_t         q_head;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MaxCharsReset;
    end else if (cfg_valid_i) begin
      max_chars_q <= max_chars_i;
    end
  end

  // front: accept and classify
  u2c_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_entry)
  );

  // decoupling queue
  u2c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head)
  );

  // back: sequence decode, limit, terminator, output register
  u2c_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_chars_i (max_chars_q),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o)
  );

endmodule
